>>> rtl/nplt_pkg.sv
`default_nettype none

package nplt_pkg;

    // Operation codes carried by an input transaction.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // Transmit modes.
    localparam logic [1:0] MODE_NORMAL     = 2'd0;
    localparam logic [1:0] MODE_NIBBLE0    = 2'd1;
    localparam logic [1:0] MODE_IDLE_LEVEL = 2'd2;
    localparam logic [1:0] MODE_RESERVED   = 2'd3;

    // Configuration register map.
    localparam int         CFG_INDEX_W       = 3;
    localparam int         CFG_DATA_W        = 16;
    localparam logic [2:0] CFG_PWM_MIN       = 3'd0;
    localparam logic [2:0] CFG_PWM_MAX       = 3'd1;
    localparam logic [2:0] CFG_MODE          = 3'd2;
    localparam logic [2:0] CFG_SYNC_MIN_US   = 3'd3;
    localparam logic [2:0] CFG_PERIOD_MIN_US = 3'd4;

    // Register reset values.
    localparam logic [7:0]  PWM_MIN_RESET       = 8'd0;
    localparam logic [7:0]  PWM_MAX_RESET       = 8'd255;
    localparam logic [15:0] SYNC_MIN_US_RESET   = 16'd4000;
    localparam logic [15:0] PERIOD_MIN_US_RESET = 16'd15000;

    // Level index: sixteen nibble values plus the idle level.
    localparam int         LEVEL_IDX_W = 5;
    localparam logic [4:0] IDLE_INDEX  = 5'd16;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    // Reciprocal of 34 in 20-bit fixed point, rounded up. It gives the exact
    // truncated quotient for every dividend below 58254.
    localparam int          RECIP_SHIFT = 20;
    localparam logic [14:0] RECIP_34    = 15'd30841;
    localparam int          RECIP_W     = 23;

    // Limits of the nibble scale, handed to the level unit.
    typedef struct packed {
        logic [7:0] pwm_min;
        logic [7:0] pwm_max;
    } level_cfg_t;

endpackage

`default_nettype wire

>>> rtl/nplt_if.sv
`default_nettype none

// Input channel: one transaction per operation.
interface nplt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       pulse_level;

    modport source (output valid, output operation, output data_byte,
                    output pulse_level, input ready);
    modport sink   (input valid, input operation, input data_byte,
                    input pulse_level, output ready);
endinterface

// Result channel: one transaction per input transaction.
interface nplt_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       frame_sync;
    logic [7:0] duty_level;
    logic       fifo_empty;

    modport source (output valid, output accepted, output frame_sync,
                    output duty_level, output fifo_empty, input ready);
    modport sink   (input valid, input accepted, input frame_sync,
                    input duty_level, input fifo_empty, output ready);
endinterface

`default_nettype wire

>>> rtl/nplt_ram.sv
`default_nettype none

module nplt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port; a read of the address
    // being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/nplt_level.sv
`default_nettype none

module nplt_level
    import nplt_pkg::*;
(
    input  wire logic                   clk,
    input  wire level_cfg_t             cfg,
    input  wire logic [LEVEL_IDX_W-1:0] idx,
    output logic      [7:0]             level
);

    logic signed [8:0]         span;
    logic                      span_neg;
    logic [7:0]                span_mag;
    logic [RECIP_W-1:0]        recip_next;
    logic [RECIP_W-1:0]        recip_reg;
    logic                      neg_reg;
    logic [LEVEL_IDX_W:0]      odd_mult;
    logic [RECIP_W+5:0]        prod;
    logic [7:0]                quot_mag;
    logic [7:0]                quot;

    // Span of the scale scaled by 1/34, taken from a register. The user must
    // change the limits only while the block is idle, which it does not enforce.
    always_comb
    begin
        span       = $signed({1'b0, cfg.pwm_max}) - $signed({1'b0, cfg.pwm_min});
        span_neg   = span[8];
        span_mag   = span_neg ? 8'(-span) : span[7:0];
        recip_next = RECIP_W'(span_mag * RECIP_34);
    end

    always_ff @(posedge clk)
    begin
        recip_reg <= recip_next;
        neg_reg   <= span_neg;
    end

    // Level for index n: min + trunc((2n+1) * span / 34), wrapped to 8 bits.
    always_comb
    begin
        odd_mult = {idx, 1'b1};
        prod     = odd_mult * recip_reg;
        quot_mag = prod[RECIP_SHIFT +: 8];
        quot     = neg_reg ? 8'(-quot_mag) : quot_mag;
        level    = cfg.pwm_min + quot;
    end

endmodule

`default_nettype wire

>>> rtl/nibble_pwm_link_transmitter.sv
// A transaction is taken into the input register; it stays there while the
// result channel stalls, and its result is then held in the result register.
// Throughput: one transaction per cycle while the result channel does not
// stall, set by the single-pass update of the FIFO indexes, the timers and
// the level multiplier.
// Reset: control state and timers clear, configuration registers take their
// defaults; the byte store holds undefined data until written.
`default_nettype none

module nibble_pwm_link_transmitter
    import nplt_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    nplt_in_if.sink                     items,
    nplt_out_if.source                  results,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int            AW       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

    // Configuration registers.
    logic [7:0]  pwm_min_reg;
    logic [7:0]  pwm_max_reg;
    logic [1:0]  mode_reg;
    logic [15:0] sync_min_reg;
    logic [15:0] period_min_reg;

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [7:0]  data_reg;
    logic        lvl_reg;

    // Link state.
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW-1:0] wr_reg, wr_next;
    logic [7:0]    held_reg, held_next;
    logic          pending_reg, pending_next;
    logic          last_lvl_reg, last_lvl_next;
    logic [15:0]   level_tmr_reg, level_tmr_next;
    logic [15:0]   period_tmr_reg, period_tmr_next;

    // Head-of-queue forwarding around the store.
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;
    logic [7:0]    ram_rdata;
    logic [7:0]    head_byte;

    // Result register.
    logic          res_valid_reg;
    logic          res_accepted_reg;
    logic          res_sync_reg;
    logic [7:0]    res_duty_reg;
    logic          res_empty_reg;

    logic                   adv;
    logic                   fire;
    logic                   ram_we;
    logic                   accepted;
    logic                   sync;
    logic [LEVEL_IDX_W-1:0] lvl_idx;
    logic [7:0]             level;
    logic [AW-1:0]          wr_inc;
    logic [15:0]            period_inc;
    logic [15:0]            level_inc;
    level_cfg_t             level_cfg;

    function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    // Configuration writes; a reserved mode value is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_min_reg    <= PWM_MIN_RESET;
            pwm_max_reg    <= PWM_MAX_RESET;
            mode_reg       <= MODE_NORMAL;
            sync_min_reg   <= SYNC_MIN_US_RESET;
            period_min_reg <= PERIOD_MIN_US_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PWM_MIN:       pwm_min_reg <= cfg_wdata[7:0];
                CFG_PWM_MAX:       pwm_max_reg <= cfg_wdata[7:0];
                CFG_MODE:
                begin
                    if (cfg_wdata[1:0] != MODE_RESERVED)
                    begin
                        mode_reg <= cfg_wdata[1:0];
                    end
                end
                CFG_SYNC_MIN_US:   sync_min_reg   <= cfg_wdata;
                CFG_PERIOD_MIN_US: period_min_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Handshake: the input register advances whenever the result register
    // is free or being emptied.
    assign adv         = !res_valid_reg || results.ready;
    assign fire        = in_valid_reg && adv;
    assign items.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            in_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            op_reg   <= items.operation;
            data_reg <= items.data_byte;
            lvl_reg  <= items.pulse_level;
        end
    end

    // The byte at the read index, with a write to that same address in the
    // previous cycle taken from the forwarding register.
    assign head_byte = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    // Single-pass update for the transaction in the input register.
    always_comb
    begin
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        held_next       = held_reg;
        pending_next    = pending_reg;
        last_lvl_next   = last_lvl_reg;
        level_tmr_next  = level_tmr_reg;
        period_tmr_next = period_tmr_reg;
        ram_we          = 1'b0;
        accepted        = 1'b0;
        sync            = 1'b0;
        lvl_idx         = IDLE_INDEX;
        wr_inc          = inc_idx(wr_reg);
        period_inc      = (period_tmr_reg == TIMER_MAX) ? TIMER_MAX : period_tmr_reg + 16'd1;
        level_inc       = (level_tmr_reg == TIMER_MAX) ? TIMER_MAX : level_tmr_reg + 16'd1;

        if (fire)
        begin
            case (op_reg)
                OP_WRITE:
                begin
                    if (wr_inc != rd_reg)
                    begin
                        ram_we   = 1'b1;
                        wr_next  = wr_inc;
                        accepted = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    period_tmr_next = period_inc;
                    if (lvl_reg != last_lvl_reg)
                    begin
                        last_lvl_next  = lvl_reg;
                        level_tmr_next = 16'd0;
                    end
                    else
                    begin
                        level_tmr_next = level_inc;
                        if (level_inc >= sync_min_reg && period_inc >= period_min_reg)
                        begin
                            period_tmr_next = 16'd0;
                            sync            = 1'b1;
                            // A pending low nibble goes first in every mode.
                            if (pending_reg)
                            begin
                                pending_next = 1'b0;
                                lvl_idx      = {1'b0, held_reg[3:0]};
                            end
                            else if (mode_reg == MODE_NIBBLE0)
                            begin
                                lvl_idx = '0;
                            end
                            else if (mode_reg == MODE_NORMAL && rd_reg != wr_reg)
                            begin
                                held_next    = head_byte;
                                rd_next      = inc_idx(rd_reg);
                                pending_next = 1'b1;
                                lvl_idx      = {1'b0, head_byte[7:4]};
                            end
                            else
                            begin
                                lvl_idx = IDLE_INDEX;
                            end
                        end
                    end
                end
                OP_FLUSH:
                begin
                    rd_next = '0;
                    wr_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg         <= '0;
            wr_reg         <= '0;
            held_reg       <= 8'd0;
            pending_reg    <= 1'b0;
            last_lvl_reg   <= 1'b0;
            level_tmr_reg  <= 16'd0;
            period_tmr_reg <= 16'd0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            held_reg       <= held_next;
            pending_reg    <= pending_next;
            last_lvl_reg   <= last_lvl_next;
            level_tmr_reg  <= level_tmr_next;
            period_tmr_reg <= period_tmr_next;
            fwd_hit_reg    <= ram_we && (wr_reg == rd_next);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= data_reg;
    end

    // Byte store, read ahead at the next read index.
    nplt_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_reg),
        .wdata (data_reg),
        .raddr (rd_next),
        .rdata (ram_rdata)
    );

    // Duty level for the selected nibble index.
    assign level_cfg.pwm_min = pwm_min_reg;
    assign level_cfg.pwm_max = pwm_max_reg;

    nplt_level u_level (
        .clk   (clk),
        .cfg   (level_cfg),
        .idx   (lvl_idx),
        .level (level)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_accepted_reg <= accepted;
            res_sync_reg     <= sync;
            res_duty_reg     <= sync ? level : 8'd0;
            res_empty_reg    <= (rd_next == wr_next);
        end
    end

    assign results.valid      = res_valid_reg;
    assign results.accepted   = res_accepted_reg;
    assign results.frame_sync = res_sync_reg;
    assign results.duty_level = res_duty_reg;
    assign results.fifo_empty = res_empty_reg;

    // A stored byte leaves the queue non-empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.accepted |-> !results.fifo_empty)
        else $error("accepted write reported an empty queue");

    // A write and a frame sync never come from the same transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> !(results.accepted && results.frame_sync))
        else $error("write and frame sync in one result");

    // A transaction held in the input register is not lost while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !adv |=> in_valid_reg)
        else $error("stalled transaction dropped from input register");

    // Forwarding only applies when the queue was empty at the write.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && (wr_reg == rd_next) |-> (wr_reg == rd_reg))
        else $error("forwarding hit on a non-empty queue");

endmodule

`default_nettype wire
